// ===== hdl/cdfrs_pkg.sv =====
// Shared constants and item types for the cumulative-weight index selector.
`default_nettype none
package cdfrs_pkg;

  localparam int MAX_PARTICLES = 256;
  localparam int IDX_W         = $clog2(MAX_PARTICLES);
  localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
  localparam int TOTAL_W       = 24;
  localparam int WEIGHT_W      = 16;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] weight;
    logic [15:0] sample;
  } item_t;

  typedef struct packed {
    logic [7:0] chosen_index;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic load;
    logic draw;
    logic clear;
    logic step;
    logic capture;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic converged;
  } stat_t;

endpackage
`default_nettype wire

// ===== hdl/cdfrs_ctrl.sv =====
// Controller: accepts items, sequences the table search and drives the result strobe.
`default_nettype none
module cdfrs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [1:0]       operation,
  input  wire cdfrs_pkg::stat_t stat,
  output cdfrs_pkg::cmd_t       cmd,
  output logic                  busy,
  output logic                  done
);

  typedef enum logic [1:0] {
    IDLE   = 2'b01,
    SEARCH = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = start && (state == IDLE);
  assign busy   = (state == SEARCH);

  always_comb begin
    cmd.load    = accept && (operation == cdfrs_pkg::OP_LOAD);
    cmd.draw    = accept && (operation == cdfrs_pkg::OP_DRAW);
    cmd.clear   = accept && (operation == cdfrs_pkg::OP_CLEAR);
    cmd.step    = (state == SEARCH);
    cmd.capture = cmd.load || (cmd.draw && stat.empty) || (cmd.step && stat.converged);
  end

  always_comb begin
    state_next = state;
    case (state)
      IDLE: begin
        if (cmd.draw && !stat.empty) state_next = SEARCH;
      end
      SEARCH: begin
        if (stat.converged) state_next = IDLE;
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.capture;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/cdfrs_dp.sv =====
// Datapath: cumulative weight table, running total and binary search registers.
`default_nettype none
module cdfrs_dp (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cdfrs_pkg::item_t item,
  input  wire cdfrs_pkg::cmd_t  cmd,
  output cdfrs_pkg::stat_t      stat,
  output cdfrs_pkg::result_t    result
);

  localparam int IW = cdfrs_pkg::IDX_W;
  localparam int CW = cdfrs_pkg::CNT_W;
  localparam int TW = cdfrs_pkg::TOTAL_W;
  localparam logic [CW-1:0] MAX_COUNT = CW'(cdfrs_pkg::MAX_PARTICLES);

  logic [TW-1:0] mem [cdfrs_pkg::MAX_PARTICLES];
  logic [TW-1:0] rdata;

  logic [CW-1:0] count;
  logic [TW-1:0] total;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi;
  logic [IW-1:0] mid;
  logic [15:0]   sample;

  logic          full;
  logic [TW:0]   sum_raw;
  logic [TW-1:0] sum_sat;
  logic          wr_en;
  logic [IW-1:0] rd_addr;
  logic [CW-1:0] half_count;
  logic          ge;
  logic [CW-1:0] mid_ext;
  logic [CW-1:0] lo_next;
  logic [CW-1:0] hi_next;
  logic [CW:0]   lh_sum;
  logic [IW-1:0] mid_next;
  logic [CW+7:0] lo_wide;
  cdfrs_pkg::result_t result_next;

  assign full       = (count >= MAX_COUNT);
  assign sum_raw    = {1'b0, total} + {{(TW + 1 - cdfrs_pkg::WEIGHT_W){1'b0}}, item.weight};
  assign sum_sat    = sum_raw[TW] ? {TW{1'b1}} : sum_raw[TW-1:0];
  assign wr_en      = cmd.load && !full;
  assign half_count = count >> 1;

  assign ge       = (rdata >= {{(TW - 16){1'b0}}, sample});
  assign mid_ext  = {{(CW - IW){1'b0}}, mid};
  assign lo_next  = ge ? lo : (mid_ext + 1'b1);
  assign hi_next  = ge ? mid_ext : hi;
  assign lh_sum   = {1'b0, lo_next} + {1'b0, hi_next};
  assign mid_next = lh_sum[IW:1];
  assign rd_addr  = cmd.step ? mid_next : half_count[IW-1:0];
  assign lo_wide  = {8'd0, lo_next};

  assign stat.empty     = (count == '0);
  assign stat.converged = (lo_next == hi_next);

  always_ff @(posedge clk) begin
    if (wr_en) mem[count[IW-1:0]] <= sum_sat;
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
    end else if (cmd.clear) begin
      count <= '0;
      total <= '0;
    end else if (wr_en) begin
      count <= count + 1'b1;
      total <= sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.draw) begin
      sample <= item.sample;
      lo     <= '0;
      hi     <= count;
      mid    <= half_count[IW-1:0];
    end else if (cmd.step) begin
      lo  <= lo_next;
      hi  <= hi_next;
      mid <= mid_next;
    end
  end

  always_comb begin
    result_next.chosen_index = 8'd0;
    result_next.status       = cdfrs_pkg::ST_OK;
    if (cmd.load) begin
      if (full) result_next.status = cdfrs_pkg::ST_TABLE_FULL;
    end else if (cmd.step) begin
      if (lo_next < count) begin
        result_next.chosen_index = lo_wide[7:0];
      end else begin
        result_next.status = cdfrs_pkg::ST_NOT_FOUND;
      end
    end else begin
      result_next.status = cdfrs_pkg::ST_NOT_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) result <= result_next;
  end

endmodule
`default_nettype wire

// ===== hdl/cdf_resampling_index_selector_top.sv =====
// Top level of the particle resampler: inverse-CDF index selection over a weight table.
// Load and clear items finish at the accept edge; a load result strobes on the next cycle.
// A draw holds busy through its binary-search steps, one table read each;
// the result strobes next cycle.
// An empty-table draw strobes not_found in the cycle after accept without raising busy.
// Reset clears the entry count and running total; table contents need no clearing.
`default_nettype none
module cdf_resampling_index_selector_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire cdfrs_pkg::item_t   item,
  output logic                    busy,
  output logic                    done,
  output cdfrs_pkg::result_t      result
);

  cdfrs_pkg::cmd_t  cmd;
  cdfrs_pkg::stat_t stat;

  cdfrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (item.operation),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done)
  );

  cdfrs_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .result (result)
  );

  a_no_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done) else $error("result strobe during search");

  a_load_answers: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.operation == cdfrs_pkg::OP_LOAD) |=> done)
    else $error("load item gave no result");

  a_clear_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.operation == cdfrs_pkg::OP_CLEAR) |=> !done)
    else $error("clear item gave a result");

  a_search_ends_with_result: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> done)
    else $error("search ended without result");

endmodule
`default_nettype wire
